### rtl/recurring_decimal_finder_defines.svh
// ----------------------------------------------------------------------------
// recurring_decimal_finder_defines
// assertion macros for the recurring decimal finder
// ----------------------------------------------------------------------------
`ifndef RECURRING_DECIMAL_FINDER_DEFINES_SVH
`define RECURRING_DECIMAL_FINDER_DEFINES_SVH

`ifndef SYNTHESIS
`define RDF_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");
`define RDF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next cycle check failed");
`else
`define RDF_ASSERT_IMPLY(label, ante, cons)
`define RDF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/rdf_pkg.sv
// ----------------------------------------------------------------------------
// rdf_pkg
// types and constants of the recurring decimal finder
// ----------------------------------------------------------------------------
package rdf_pkg;

   localparam int HIST_DEPTH = 64;
   localparam int ADDR_W     = (HIST_DEPTH > 2) ? $clog2(HIST_DEPTH) : 1;
   localparam int REM_W      = 29;
   localparam int PROD_W     = REM_W + 4;
   localparam int LIMIT_W    = 7;
   localparam int CMP_W      = 8;
   localparam logic [CMP_W-1:0] DEPTH_LIM = CMP_W'(HIST_DEPTH);

   typedef enum logic [1:0] {
      STATUS_RECUR   = 2'd0,
      STATUS_PLAIN   = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef struct packed {
      logic [REM_W-1:0]   numerator;
      logic [REM_W-1:0]   denominator;
      logic [LIMIT_W-1:0] digit_limit;
   } req_type;

   typedef struct packed {
      logic [3:0] digit;
      logic       in_cycle;
      status_type status;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [3:0]       digit;
      logic [REM_W-1:0] remainder;
   } hist_entry_type;

endpackage

### rtl/recurring_decimal_finder.sv
// ----------------------------------------------------------------------------
// recurring_decimal_finder
// long division of a proper fraction with detection of the repeating part
// sequence: a start check, then per digit a division step per quotient bit, a
// history write and a search of the earlier entries, then one output per digit
// throughput: one transaction at a time, set by the shared subtract/compare unit
// and the single history memory port
// reset: synchronous, clears the sequencer and the result valid; history is not cleared
// ----------------------------------------------------------------------------
`include "recurring_decimal_finder_defines.svh"

module recurring_decimal_finder
   import rdf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_DIV,
      S_WRITE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_NEXT,
      S_OUT_RD,
      S_OUT_LD,
      S_EMIT
   } state_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [3:0]        q_ff, q_in;
   logic [1:0]        bit_ff, bit_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] match_ff, match_in;
   status_type        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_payload_ff, rsp_payload_in;

   hist_entry_type    hist_mem [HIST_DEPTH];
   hist_entry_type    rd_data_ff;
   hist_entry_type    wr_data;
   logic              mem_we;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_addr;

   logic              slot_free;
   logic [PROD_W-1:0] den_shift;
   logic [CMP_W-1:0]  pos_inc;
   logic [CMP_W-1:0]  limit_ext;
   logic [ADDR_W-1:0] pos_last;
   logic [REM_W-1:0]  cur_rem;

   function automatic logic [PROD_W-1:0] times_ten(input logic [REM_W-1:0] x);
      logic [PROD_W-1:0] w;
      w = PROD_W'(x);
      return (w << 3) + (w << 1);
   endfunction

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign den_shift = PROD_W'(req_ff.denominator) << bit_ff;
   assign pos_inc   = CMP_W'(pos_ff) + CMP_W'(1);
   assign limit_ext = CMP_W'(req_ff.digit_limit);
   assign pos_last  = pos_ff - 1'b1;
   assign cur_rem   = prod_ff[REM_W-1:0];
   assign wr_data   = '{digit: q_ff, remainder: cur_rem};

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      prod_in        = prod_ff;
      q_in           = q_ff;
      bit_in         = bit_ff;
      pos_in         = pos_ff;
      idx_in         = idx_ff;
      match_in       = match_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_addr       = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = S_START;
            end
         end
         S_START: begin
            if (req_ff.denominator == '0 || req_ff.numerator >= req_ff.denominator) begin
               status_in = STATUS_INVALID;
               state_in  = S_EMIT;
            end else begin
               prod_in  = times_ten(req_ff.numerator);
               q_in     = '0;
               bit_in   = 2'd3;
               pos_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (prod_ff >= den_shift) begin
               prod_in = prod_ff - den_shift;
               q_in    = q_ff | (4'd1 << bit_ff);
            end
            if (bit_ff == 2'd0) begin
               state_in = S_WRITE;
            end else begin
               bit_in = bit_ff - 2'd1;
            end
         end
         S_WRITE: begin
            mem_we   = 1'b1;
            mem_addr = pos_ff;
            idx_in   = '0;
            state_in = (pos_ff == '0) ? S_NEXT : S_SCAN_RD;
         end
         S_SCAN_RD: begin
            mem_re   = 1'b1;
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (rd_data_ff == wr_data) begin
               if (cur_rem != '0) begin
                  match_in = idx_ff;
                  idx_in   = '0;
                  state_in = S_OUT_RD;
               end else begin
                  status_in = STATUS_PLAIN;
                  state_in  = S_EMIT;
               end
            end else if (idx_ff == pos_last) begin
               state_in = S_NEXT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_NEXT: begin
            if (pos_inc >= limit_ext || pos_inc >= DEPTH_LIM) begin
               status_in = STATUS_PLAIN;
               state_in  = S_EMIT;
            end else begin
               pos_in   = pos_ff + 1'b1;
               prod_in  = times_ten(cur_rem);
               q_in     = '0;
               bit_in   = 2'd3;
               state_in = S_DIV;
            end
         end
         S_OUT_RD: begin
            mem_re   = 1'b1;
            state_in = S_OUT_LD;
         end
         S_OUT_LD: begin
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_payload_in.digit    = rd_data_ff.digit;
               rsp_payload_in.in_cycle = (idx_ff >= match_ff);
               rsp_payload_in.status   = STATUS_RECUR;
               rsp_payload_in.last     = (idx_ff == pos_last);
               if (idx_ff == pos_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_OUT_RD;
               end
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_payload_in.digit    = '0;
               rsp_payload_in.in_cycle = 1'b0;
               rsp_payload_in.status   = status_ff;
               rsp_payload_in.last     = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff         <= req_in;
      prod_ff        <= prod_in;
      q_ff           <= q_in;
      bit_ff         <= bit_in;
      pos_ff         <= pos_in;
      idx_ff         <= idx_in;
      match_ff       <= match_in;
      status_ff      <= status_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   // digit and remainder history
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= hist_mem[mem_addr];
      end
   end

   `RDF_ASSERT_IMPLY(a_non_recur_single, rsp_valid && rsp_payload.status != STATUS_RECUR, rsp_payload.last)
   `RDF_ASSERT_IMPLY(a_digit_decimal, rsp_valid, rsp_payload.digit <= 4'd9)
   `RDF_ASSERT_IMPLY(a_scan_in_range, state_ff == S_SCAN_CMP, idx_ff < pos_ff)
   `RDF_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, state_ff == S_START)

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for recurring_decimal_finder. It runs a table of
// fractions covering the extremes and the edge cases first, then about a
// hundred random fractions. Each untyped input goes through a long-division
// model kept in the bench, and every returned digit is checked field by field
// in arrival order. Both sides idle at random in several phases. One phase
// holds the response side off for a long stretch while requests keep coming.
// ----------------------------------------------------------------------------
module tb_top;
   import rdf_pkg::*;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type typed_rsp;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   rsp_type     expected_digits[$];
   dir_row_type directed_rows[$];
   int          fail_count = 0;
   int          sender_idle_pct = 0;
   int          stall_pct = 0;
   bit          pressure_go = 1'b0;
   bit          pressure_seen = 1'b0;
   int          hold_left = 0;

   recurring_decimal_finder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   function automatic rsp_type single_result(status_type st);
      rsp_type r;
      r.digit    = 4'd0;
      r.in_cycle = 1'b0;
      r.status   = st;
      r.last     = 1'b1;
      return r;
   endfunction

   function automatic dir_row_type mk_row(int unsigned num, int unsigned den,
                                          int unsigned lim, bit typed,
                                          status_type st);
      dir_row_type row;
      row.req.numerator   = num[REM_W-1:0];
      row.req.denominator = den[REM_W-1:0];
      row.req.digit_limit = lim[LIMIT_W-1:0];
      row.typed           = typed;
      row.typed_rsp       = single_result(st);
      return row;
   endfunction

   // long division with a search of the (digit, remainder) history
   task automatic predict_expansion(input req_type r);
      logic [3:0]       dig_hist [HIST_DEPTH];
      logic [REM_W-1:0] rem_hist [HIST_DEPTH];
      logic [REM_W-1:0] rem;
      logic [PROD_W:0]  prod;
      logic [PROD_W:0]  quot;
      rsp_type          res;
      int               lim;
      int               pos;
      if (r.denominator == '0 || r.numerator >= r.denominator) begin
         expected_digits.push_back(single_result(STATUS_INVALID));
         return;
      end
      lim = r.digit_limit;
      if (lim > HIST_DEPTH) begin
         lim = HIST_DEPTH;
      end
      rem = r.numerator;
      pos = 0;
      forever begin
         prod = {{(PROD_W + 1 - REM_W){1'b0}}, rem} * 10;
         quot = prod / {{(PROD_W + 1 - REM_W){1'b0}}, r.denominator};
         rem  = REM_W'(prod - quot * r.denominator);
         dig_hist[pos] = quot[3:0];
         rem_hist[pos] = rem;
         for (int j = 0; j < pos; j++) begin
            if (dig_hist[j] == dig_hist[pos] && rem_hist[j] == rem_hist[pos]) begin
               if (rem_hist[j] != '0) begin
                  for (int k = 0; k < pos; k++) begin
                     res.digit    = dig_hist[k];
                     res.in_cycle = (k >= j);
                     res.status   = STATUS_RECUR;
                     res.last     = (k == pos - 1);
                     expected_digits.push_back(res);
                  end
               end else begin
                  expected_digits.push_back(single_result(STATUS_PLAIN));
               end
               return;
            end
         end
         pos++;
         if (pos >= lim) begin
            break;
         end
      end
      expected_digits.push_back(single_result(STATUS_PLAIN));
   endtask

   // called at a rising edge; returns at the edge where the transaction is taken
   task automatic send_fraction(input req_type r, input bit typed, input rsp_type typed_rsp);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do begin
         @(posedge clock);
      end while (!req_ready);
      if (typed) begin
         expected_digits.push_back(typed_rsp);
      end else begin
         predict_expansion(r);
      end
   endtask

   function automatic req_type random_fraction();
      req_type     r;
      int unsigned sel;
      int unsigned den;
      int unsigned num;
      int unsigned lim;
      sel = $urandom_range(99);
      lim = $urandom_range(127);
      if (sel < 10) begin
         den = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 29'h1FFFFFFF);
         num = $urandom_range(29'h1FFFFFFF, den);
      end else if (sel < 50) begin
         den = $urandom_range(2, 400);
         num = $urandom_range(den - 1);
         lim = $urandom_range(32, 127);
      end else if (sel < 70) begin
         den = $urandom_range(2, 50000);
         num = $urandom_range(den - 1);
      end else if (sel < 90) begin
         den = $urandom_range(2, 29'h1FFFFFFF);
         num = $urandom_range(den - 1);
      end else begin
         den = $urandom_range(1, 29'h1FFFFFFF);
         num = $urandom_range(den - 1);
         lim = $urandom_range(3);
      end
      r.numerator   = num[REM_W-1:0];
      r.denominator = den[REM_W-1:0];
      r.digit_limit = lim[LIMIT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin : rsp_side
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_digits.size() == 0) begin
            $error("unexpected result transaction: digit %0d status %0d",
                   rsp_payload.digit, rsp_payload.status);
            fail_count++;
         end else begin
            want = expected_digits.pop_front();
            if (rsp_payload.digit !== want.digit) begin
               $error("digit: expected %0d, got %0d", want.digit, rsp_payload.digit);
               fail_count++;
            end
            if (rsp_payload.in_cycle !== want.in_cycle) begin
               $error("in_cycle: expected %0d, got %0d", want.in_cycle,
                      rsp_payload.in_cycle);
               fail_count++;
            end
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
               fail_count++;
            end
            if (rsp_payload.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_payload.last);
               fail_count++;
            end
         end
      end
      if (pressure_go && !pressure_seen) begin
         pressure_seen = 1'b1;
         hold_left     = 3000;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      #50ms;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      directed_rows.push_back(mk_row(0, 0, 10, 1, STATUS_INVALID));
      directed_rows.push_back(mk_row(29'h1FFFFFFF, 0, 127, 1, STATUS_INVALID));
      directed_rows.push_back(mk_row(5, 5, 64, 1, STATUS_INVALID));
      directed_rows.push_back(mk_row(29'h1FFFFFFF, 29'h10000000, 64, 1, STATUS_INVALID));
      directed_rows.push_back(mk_row(22, 7, 64, 1, STATUS_INVALID));
      directed_rows.push_back(mk_row(0, 7, 10, 1, STATUS_PLAIN));
      directed_rows.push_back(mk_row(0, 1, 1, 1, STATUS_PLAIN));
      directed_rows.push_back(mk_row(1, 3, 0, 1, STATUS_PLAIN));
      directed_rows.push_back(mk_row(1, 3, 1, 1, STATUS_PLAIN));
      directed_rows.push_back(mk_row(1, 3, 2, 0, STATUS_RECUR));
      directed_rows.push_back(mk_row(1, 3, 127, 0, STATUS_RECUR));
      directed_rows.push_back(mk_row(1, 6, 64, 0, STATUS_RECUR));
      directed_rows.push_back(mk_row(1, 7, 127, 0, STATUS_RECUR));
      directed_rows.push_back(mk_row(3, 7, 64, 0, STATUS_RECUR));
      directed_rows.push_back(mk_row(1, 8, 64, 1, STATUS_PLAIN));
      directed_rows.push_back(mk_row(1, 97, 127, 1, STATUS_PLAIN));
      directed_rows.push_back(mk_row(1, 61, 64, 0, STATUS_RECUR));
      directed_rows.push_back(mk_row(1, 61, 60, 1, STATUS_PLAIN));
      directed_rows.push_back(mk_row(1, 61, 61, 0, STATUS_RECUR));
      directed_rows.push_back(mk_row(29'h1FFFFFFE, 29'h1FFFFFFF, 64, 0, STATUS_RECUR));
      directed_rows.push_back(mk_row(1, 29'h1FFFFFFF, 127, 0, STATUS_RECUR));
      directed_rows.push_back(mk_row(29'h0AAAAAAA, 29'h15555555, 64, 0, STATUS_RECUR));
      directed_rows.push_back(mk_row(1, 9999999, 127, 0, STATUS_RECUR));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_fraction(directed_rows[i].req, directed_rows[i].typed,
                       directed_rows[i].typed_rsp);
      end

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1: begin
               sender_idle_pct = 72;
               stall_pct       = 0;
            end
            2: begin
               sender_idle_pct = 0;
               stall_pct       = 72;
            end
            3: begin
               sender_idle_pct = 29;
               stall_pct       = 29;
            end
            default: begin
               sender_idle_pct = 0;
               stall_pct       = 0;
            end
         endcase
         if (phase == 4) begin
            pressure_go = 1'b1;
         end
         for (int n = 0; n < 20; n++) begin
            send_fraction(random_fraction(), 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      while (expected_digits.size() != 0) begin
         @(posedge clock);
      end
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
